@@ design/srpt_pkg.sv @@
// Shared types and constants for the SRPT data packet scheduler.
package srpt_pkg;

    // Field widths fixed by the packet format
    localparam int IDX_W  = 6;
    localparam int BYTE_W = 32;
    localparam int PS_W   = 16;

    localparam logic [PS_W-1:0] PAYLOAD_SIZE_RST = 16'd1386;

    // Command codes on the input channel
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_NEW   = 2'd1;
    localparam logic [1:0] CMD_BUF   = 2'd2;
    localparam logic [1:0] CMD_GRANT = 2'd3;

    // Table update selected by the front end
    typedef enum logic [1:0] {
        UPD_NONE  = 2'd0,
        UPD_NEW   = 2'd1,
        UPD_BUF   = 2'd2,
        UPD_GRANT = 2'd3
    } upd_t;

    // One classified beat travelling from front to back
    typedef struct packed {
        upd_t              kind;
        logic [IDX_W-1:0]  idx;
        logic              act;
        logic [BYTE_W-1:0] rem;
        logic [BYTE_W-1:0] gr;
        logic [BYTE_W-1:0] bu;
    } srpt_item_t;

    // Back end sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_SEND  = 5'b10000
    } st_t;

endpackage

@@ design/srpt_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module srpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/srpt_front.sv @@
// Front end: accepts input beats, classifies the command, queues them.
module srpt_front import srpt_pkg::*; #(
    parameter int NUM_SLOTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [IDX_W-1:0]  rpc_index,
    input  logic [BYTE_W-1:0] remaining_bytes,
    input  logic [BYTE_W-1:0] granted_bytes,
    input  logic [BYTE_W-1:0] dbuffered_bytes,
    output logic              q_valid,
    output srpt_item_t        q_item,
    input  logic              q_take
);

    srpt_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       in_range;
    srpt_item_t cls;

    // classify: out-of-table ids carry no update
    assign in_range = (int'(rpc_index) < NUM_SLOTS);

    always_comb
    begin
        cls.idx = rpc_index;
        cls.act = (rpc_index != '0);
        cls.rem = remaining_bytes;
        cls.gr  = granted_bytes;
        cls.bu  = dbuffered_bytes;
        unique case (command)
            CMD_TICK:  cls.kind = UPD_NONE;
            CMD_NEW:   cls.kind = UPD_NEW;
            CMD_BUF:   cls.kind = UPD_BUF;
            CMD_GRANT: cls.kind = UPD_GRANT;
            default:   cls.kind = UPD_NONE;
        endcase
        if (!in_range)
        begin
            cls.kind = UPD_NONE;
        end
    end

    // two-entry queue
    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_take ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, q_take})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ design/srpt_back.sv @@
// Back end: applies the update, scans the slot table and sends the winner.
module srpt_back import srpt_pkg::*; #(
    parameter int NUM_SLOTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PS_W-1:0]   ps,
    input  logic              q_valid,
    input  srpt_item_t        q_item,
    output logic              q_take,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  pkt_rpc_id,
    output logic [BYTE_W-1:0] pkt_remaining,
    output logic [BYTE_W-1:0] pkt_granted,
    output logic [BYTE_W-1:0] pkt_dbuffered
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

    st_t               state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              found_reg, found_next;
    logic [AW-1:0]     best_idx_reg, best_idx_next;
    logic [BYTE_W-1:0] best_rem_reg, best_rem_next;
    logic [BYTE_W-1:0] best_gr_reg, best_gr_next;
    logic [BYTE_W-1:0] best_bu_reg, best_bu_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  o_id_reg;
    logic [BYTE_W-1:0] o_rem_reg, o_gr_reg, o_bu_reg;

    logic              ar_we, gr_we, bu_we, re;
    logic [AW-1:0]     ar_waddr, upd_addr;
    logic [BYTE_W:0]   ar_wdata, ar_rdata;
    logic [BYTE_W-1:0] gr_rdata, bu_rdata;
    logic              out_free, load_out, cand;
    logic              gr_ok, bu_ok;
    logic [BYTE_W-1:0] rem_after;

    assign upd_addr = AW'(q_item.idx);
    assign out_free = !out_valid_reg || !out_stall;
    assign q_take   = (state_reg == ST_IDLE) && q_valid;
    assign load_out = (state_reg == ST_SEND) && found_reg && out_free;
    assign re       = (state_reg == ST_SCAN);

    // remaining count after one packet, floored at zero
    assign rem_after = ({16'd0, ps} > best_rem_reg) ? '0 : (best_rem_reg - {16'd0, ps});

    // slot table: active flag with remaining, granted, buffered
    always_comb
    begin
        ar_we    = 1'b0;
        ar_waddr = upd_addr;
        ar_wdata = {q_item.act, q_item.rem};
        if (state_reg == ST_CLEAR)
        begin
            ar_we    = 1'b1;
            ar_waddr = cnt_reg;
            ar_wdata = '0;
        end
        else if (load_out)
        begin
            ar_we    = 1'b1;
            ar_waddr = best_idx_reg;
            ar_wdata = {(rem_after != '0), rem_after};
        end
        else if (q_take && (q_item.kind == UPD_NEW))
        begin
            ar_we = 1'b1;
        end
    end

    assign gr_we = q_take && ((q_item.kind == UPD_NEW) || (q_item.kind == UPD_GRANT));
    assign bu_we = q_take && ((q_item.kind == UPD_NEW) || (q_item.kind == UPD_BUF));

    srpt_ram #(.WIDTH(BYTE_W + 1), .DEPTH(NUM_SLOTS)) u_ar_ram (
        .clk   (clk),
        .we    (ar_we),
        .waddr (ar_waddr),
        .wdata (ar_wdata),
        .re    (re),
        .raddr (cnt_reg),
        .rdata (ar_rdata)
    );

    srpt_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_SLOTS)) u_gr_ram (
        .clk   (clk),
        .we    (gr_we),
        .waddr (upd_addr),
        .wdata (q_item.gr),
        .re    (re),
        .raddr (cnt_reg),
        .rdata (gr_rdata)
    );

    srpt_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_SLOTS)) u_bu_ram (
        .clk   (clk),
        .we    (bu_we),
        .waddr (upd_addr),
        .wdata (q_item.bu),
        .re    (re),
        .raddr (cnt_reg),
        .rdata (bu_rdata)
    );

    // eligibility of the slot read back this cycle
    assign gr_ok = (({1'b0, gr_rdata} + 33'd1) <= {1'b0, ar_rdata[BYTE_W-1:0]})
                   || (gr_rdata == '0);
    assign bu_ok = (({1'b0, bu_rdata} + {17'd0, ps}) <= {1'b0, ar_rdata[BYTE_W-1:0]})
                   || (bu_rdata == '0);
    assign cand  = rd_vld_reg && ar_rdata[BYTE_W] && gr_ok && bu_ok
                   && (!found_reg || (ar_rdata[BYTE_W-1:0] < best_rem_reg));

    // candidate tracking
    always_comb
    begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_rem_next = best_rem_reg;
        best_gr_next  = best_gr_reg;
        best_bu_next  = best_bu_reg;
        if (q_take)
        begin
            found_next = 1'b0;
        end
        else if (cand)
        begin
            found_next    = 1'b1;
            best_idx_next = rd_idx_reg;
            best_rem_next = ar_rdata[BYTE_W-1:0];
            best_gr_next  = gr_rdata;
            best_bu_next  = bu_rdata;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (q_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (!found_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= re;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= cnt_reg;
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_gr_reg  <= best_gr_next;
        best_bu_reg  <= best_bu_next;
        if (load_out)
        begin
            o_id_reg  <= IDX_W'(best_idx_reg);
            o_rem_reg <= best_rem_reg;
            o_gr_reg  <= best_gr_reg;
            o_bu_reg  <= best_bu_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pkt_rpc_id    = o_id_reg;
    assign pkt_remaining = o_rem_reg;
    assign pkt_granted   = o_gr_reg;
    assign pkt_dbuffered = o_bu_reg;

    // a beat is only taken between scans
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> (state_reg == ST_IDLE) && q_valid)
        else $error("queue beat taken outside idle");

    // the table is frozen while it is being scanned
    a_scan_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN) |-> !ar_we && !gr_we && !bu_we)
        else $error("table written during scan");

    // read data only arrives for addresses issued by the scan
    a_rd_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_SCAN))
        else $error("read data outside scan");

    // a packet is only loaded from an eligible candidate into a free register
    a_load_found: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (o_rem_reg == $past(best_rem_reg)))
        else $error("packet register not loaded");

endmodule

@@ design/srpt_data_packet_scheduler_core.sv @@
// Top level of the SRPT data packet scheduler: config register, front and back ends.
//
// Each input beat optionally updates one message slot, then the whole slot table
// is scanned and the active, eligible slot with the fewest remaining bytes (lowest
// index on a tie) is sent as one packet beat. An item occupies the back end for
// an update step, a read of every slot through the single read port of the slot
// RAMs, a drain step and a send step, plus any output stall. A two-beat queue in
// front keeps accepting input during a scan until both entries are full. After
// reset the table is cleared slot by slot before the first item is taken; the
// payload_size register can be written at any time the block is idle.
module srpt_data_packet_scheduler_core import srpt_pkg::*; #(
    parameter int NUM_SLOTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [PS_W-1:0]   payload_size,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [IDX_W-1:0]  rpc_index,
    input  logic [BYTE_W-1:0] remaining_bytes,
    input  logic [BYTE_W-1:0] granted_bytes,
    input  logic [BYTE_W-1:0] dbuffered_bytes,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  pkt_rpc_id,
    output logic [BYTE_W-1:0] pkt_remaining,
    output logic [BYTE_W-1:0] pkt_granted,
    output logic [BYTE_W-1:0] pkt_dbuffered
);

    logic [PS_W-1:0] ps_reg;
    logic            q_valid;
    logic            q_take;
    srpt_item_t      q_item;

    // payload size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg <= PAYLOAD_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ps_reg <= payload_size;
        end
    end

    srpt_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .rpc_index       (rpc_index),
        .remaining_bytes (remaining_bytes),
        .granted_bytes   (granted_bytes),
        .dbuffered_bytes (dbuffered_bytes),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_take          (q_take)
    );

    srpt_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ps            (ps_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_take        (q_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pkt_rpc_id    (pkt_rpc_id),
        .pkt_remaining (pkt_remaining),
        .pkt_granted   (pkt_granted),
        .pkt_dbuffered (pkt_dbuffered)
    );

endmodule
